/* rtl/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, muted while reset is active
`define MF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// a condition that must never be seen
`define MF_NEVER(lbl, cond, msg) \
	`MF_ASSERT(lbl, !(cond), msg)

`endif

/* rtl/mfrag_pkg.sv */
package mfrag_pkg;

	// flag bits of the header byte
	localparam logic [7:0] FLAG_NONE  = 8'h00;
	localparam logic [7:0] FLAG_START = 8'h01;
	localparam logic [7:0] FLAG_END   = 8'h02;

	// fragment size limits, header included
	localparam logic [7:0] PAYLOAD_MAX = 8'd244;
	localparam logic [7:0] PAYLOAD_MIN = 8'd5;

	// header lengths
	localparam logic [7:0] START_HDR = 8'd4;
	localparam logic [7:0] LATER_HDR = 8'd1;

	// result buffer depth: four header bytes and one data byte
	localparam int OBUF_DEPTH = 5;
	localparam int OBUF_CNT_W = $clog2(OBUF_DEPTH + 1);

	// configuration address map
	localparam int ADDR_W = 3;
	localparam logic [ADDR_W-1:0] REG_FRAGMENT_PAYLOAD = 3'd0;

endpackage

/* rtl/message_fragmenter_core.sv */
// Message fragmenter: takes one message byte per input beat (tdata carries the
// byte and the total message length) and emits the fragment byte stream. The
// first byte of a message is preceded by a four-byte header (flags, wrapping
// message counter, length low, length high); each later fragment opens with a
// single flag byte. Each input beat gives one to five output beats, and tlast
// marks the last output beat of each input beat. A beat whose length is zero
// at message start is dropped. Timing: an input beat is registered, then
// handed to a five-byte output shift buffer that drains one beat per cycle
// while m_tready is high, so an item costs one beat mid-fragment, two at a
// later fragment start and five at a message start; the output buffer's drain
// sets the rate. A new input beat is taken while the previous one still
// drains. The fragment size register (address 0, reset 244) is clamped to
// 5..244 and applies from the next byte.
module message_fragmenter_core
	import mfrag_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	// input stream
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [23:0]       s_tdata,  // data_byte [7:0], msg_length [23:8]
	// output stream
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,  // out_byte [7:0]
	output logic [1:0]        m_tuser,  // fragment_end [0], message_end [1]
	output logic              m_tlast   // run_last
);

	// configuration register
	logic [7:0] payload_q;

	// input stage
	logic        in_valid_s1;
	logic [7:0]  in_byte_s1;
	logic [15:0] in_len_s1;

	// message state
	logic [7:0]  msg_cnt_q;
	logic [15:0] bytes_sent_q;   // zero means no message open
	logic [15:0] len_q;
	logic [7:0]  fill_q;         // zero means no fragment open

	// output shift buffer, head at index 0
	logic [7:0]            obuf_q [OBUF_DEPTH];
	logic [OBUF_CNT_W-1:0] left_q;
	logic                  fe_q;
	logic                  me_q;

	// datapath
	logic [7:0]  p;
	logic        msg_start;
	logic        drop;
	logic        move;
	logic        load;
	logic        take;
	logic [15:0] eff_len;
	logic [15:0] bs_next;
	logic [7:0]  fill_base;
	logic [7:0]  fill_next;
	logic        me;
	logic        fe;
	logic        start_fits;
	logic        later_fits;
	logic        later_hdr;
	logic [16:0] later_sum;
	logic [7:0]  start_room;

	// apb: writes land on the access cycle, pready tied high
	assign pready = 1'b1;
	assign prdata = {24'd0, payload_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_q <= PAYLOAD_MAX;
		end else if (psel && penable && pwrite &&
				(paddr[ADDR_W-1:2] == REG_FRAGMENT_PAYLOAD[ADDR_W-1:2])) begin
			payload_q <= pwdata[7:0];
		end
	end

	// clamp the fragment size
	always_comb begin
		p = payload_q;
		if (p < PAYLOAD_MIN) begin
			p = PAYLOAD_MIN;
		end
		if (p > PAYLOAD_MAX) begin
			p = PAYLOAD_MAX;
		end
	end

	// handoff: input stage moves into the output buffer once it is empty
	// or its final beat leaves this cycle
	assign take     = m_tvalid && m_tready;
	assign move     = in_valid_s1 && ((left_q == '0) || ((left_q == OBUF_CNT_W'(1)) && m_tready));
	assign s_tready = !in_valid_s1 || move;

	assign msg_start = (bytes_sent_q == 16'd0);
	assign drop      = msg_start && (in_len_s1 == 16'd0);
	assign load      = move && !drop;

	// per-byte decisions
	assign eff_len    = msg_start ? in_len_s1 : len_q;
	assign bs_next    = msg_start ? 16'd1 : bytes_sent_q + 16'd1;
	assign later_hdr  = !msg_start && (fill_q == 8'd0);
	assign fill_base  = msg_start ? START_HDR : (later_hdr ? LATER_HDR : fill_q);
	assign fill_next  = fill_base + 8'd1;
	assign me         = (bs_next >= eff_len);
	assign fe         = me || (fill_next >= p);
	assign start_room = p - START_HDR;
	assign start_fits = ({8'd0, start_room} >= in_len_s1);
	assign later_sum  = {1'b0, bytes_sent_q} + {9'd0, p - LATER_HDR};
	assign later_fits = (later_sum >= {1'b0, len_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_byte_s1 <= s_tdata[7:0];
			in_len_s1  <= s_tdata[23:8];
		end
	end

	// message state advances when a byte is handed to the output buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_cnt_q    <= 8'd0;
			bytes_sent_q <= 16'd0;
			len_q        <= 16'd0;
			fill_q       <= 8'd0;
		end else if (load) begin
			if (msg_start) begin
				len_q     <= in_len_s1;
				msg_cnt_q <= msg_cnt_q + 8'd1;
			end
			bytes_sent_q <= me ? 16'd0 : bs_next;
			fill_q       <= fe ? 8'd0 : fill_next;
		end
	end

	// output buffer: load a whole run, then shift one beat out per take
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (load) begin
			if (msg_start) begin
				left_q <= OBUF_CNT_W'(5);
			end else if (later_hdr) begin
				left_q <= OBUF_CNT_W'(2);
			end else begin
				left_q <= OBUF_CNT_W'(1);
			end
		end else if (take) begin
			left_q <= left_q - OBUF_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			fe_q <= fe;
			me_q <= me;
			if (msg_start) begin
				obuf_q[0] <= start_fits ? (FLAG_START | FLAG_END) : FLAG_START;
				obuf_q[1] <= msg_cnt_q;
				obuf_q[2] <= in_len_s1[7:0];
				obuf_q[3] <= in_len_s1[15:8];
				obuf_q[4] <= in_byte_s1;
			end else if (later_hdr) begin
				obuf_q[0] <= later_fits ? FLAG_END : FLAG_NONE;
				obuf_q[1] <= in_byte_s1;
				for (int i = 2; i < OBUF_DEPTH; i++) begin
					obuf_q[i] <= 8'd0;
				end
			end else begin
				obuf_q[0] <= in_byte_s1;
				for (int i = 1; i < OBUF_DEPTH; i++) begin
					obuf_q[i] <= 8'd0;
				end
			end
		end else if (take) begin
			for (int i = 0; i < OBUF_DEPTH - 1; i++) begin
				obuf_q[i] <= obuf_q[i+1];
			end
			obuf_q[OBUF_DEPTH-1] <= 8'd0;
		end
	end

	// header beats carry no end marks; the data beat closes the run
	assign m_tvalid = (left_q != '0);
	assign m_tdata  = obuf_q[0];
	assign m_tlast  = (left_q == OBUF_CNT_W'(1));
	assign m_tuser  = m_tlast ? {me_q, fe_q} : 2'b00;

endmodule

/* rtl/mfrag_checker.sv */
`include "assert_macros.svh"

module mfrag_checker
	import mfrag_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              psel,
	input logic              penable,
	input logic              pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [31:0]       pwdata,
	input logic [31:0]       prdata,
	input logic              pready,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [7:0]        m_tdata,
	input logic [1:0]        m_tuser,
	input logic              m_tlast
);

	// completed write to the fragment size register
	logic cfg_wr;
	// output beat offered but not taken
	logic out_stall;

	assign cfg_wr    = psel && penable && pwrite && pready &&
		(paddr[ADDR_W-1:2] == REG_FRAGMENT_PAYLOAD[ADDR_W-1:2]);
	assign out_stall = m_tvalid && !m_tready;

	// header beats never carry end marks
	`MF_ASSERT(a_marks_on_last, (m_tvalid && !m_tlast) |-> (m_tuser == 2'b00), "end mark on header")

	// the end of a message always closes its fragment
	`MF_NEVER(a_msg_end_frag, m_tvalid && m_tuser[1] && !m_tuser[0], "message end alone")

	// a stalled output beat holds
	`MF_ASSERT(a_out_hold, out_stall |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)), "beat moved")

	// a write to the fragment size register reads back
	`MF_ASSERT(a_cfg_readback, cfg_wr |=> (prdata[7:0] == $past(pwdata[7:0])), "readback mismatch")

endmodule

bind message_fragmenter_core mfrag_checker u_mfrag_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import mfrag_pkg::*;

	// receiver hold-off that fills the block and stalls its input
	localparam int LONG_HOLD = 80;
	// quiet cycles after the last expected beat, covers the block's pipeline
	localparam int IDLE_TAIL = 12;

	// one expected output beat
	typedef struct {
		logic [7:0] out_byte;
		logic       frag_end;
		logic       msg_end;
		logic       run_last;
	} frag_beat_t;

	// tracks the fragmenter state and the fragment bytes still owed by the block
	class fragment_tracker;
		logic [7:0]  size_reg;
		logic [7:0]  msg_count;
		logic [15:0] sent;
		logic [15:0] length;
		logic [7:0]  fill;
		frag_beat_t  owed_bytes[$];
		int          errors;
		int          beats_in;
		int          beats_out;
		int          dropped;
		int          messages;

		function new();
			size_reg  = PAYLOAD_MAX;
			msg_count = '0;
			sent      = '0;
			length    = '0;
			fill      = '0;
			errors    = 0;
			beats_in  = 0;
			beats_out = 0;
			dropped   = 0;
			messages  = 0;
		endfunction

		function void set_size(logic [7:0] value);
			size_reg = value;
		endfunction

		function bit open();
			return sent != 0;
		endfunction

		function logic [15:0] cur_length();
			return length;
		endfunction

		function int pending();
			return owed_bytes.size();
		endfunction

		function void owe(logic [7:0] b, logic fe, logic me, logic last);
			frag_beat_t e;
			e.out_byte = b;
			e.frag_end = fe;
			e.msg_end  = me;
			e.run_last = last;
			owed_bytes.push_back(e);
		endfunction

		// accepted input beat: work out the fragment bytes it causes
		function void take_byte(logic [7:0] data, logic [15:0] len);
			int         size;
			logic [7:0] flags;
			logic       fe;
			logic       me;
			size = int'(size_reg);
			if (size < int'(PAYLOAD_MIN)) size = int'(PAYLOAD_MIN);
			if (size > int'(PAYLOAD_MAX)) size = int'(PAYLOAD_MAX);
			beats_in++;
			if (sent == 0) begin
				if (len == 0) begin
					dropped++;
					return;
				end
				messages++;
				length = len;
				flags = FLAG_START;
				if (size - int'(START_HDR) >= int'(length)) flags = flags | FLAG_END;
				owe(flags, 1'b0, 1'b0, 1'b0);
				owe(msg_count, 1'b0, 1'b0, 1'b0);
				msg_count = msg_count + 8'd1;
				owe(length[7:0], 1'b0, 1'b0, 1'b0);
				owe(length[15:8], 1'b0, 1'b0, 1'b0);
				fill = START_HDR;
			end else if (fill == 0) begin
				flags = FLAG_NONE;
				if (int'(sent) + size - int'(LATER_HDR) >= int'(length)) flags = FLAG_END;
				owe(flags, 1'b0, 1'b0, 1'b0);
				fill = LATER_HDR;
			end
			sent = sent + 16'd1;
			fill = fill + 8'd1;
			me = (sent >= length);
			fe = me || (int'(fill) >= size);
			owe(data, fe, me, 1'b1);
			if (me) begin
				sent = '0;
				fill = '0;
			end else if (fe) begin
				fill = '0;
			end
		endfunction

		// accepted output beat against the oldest owed byte
		function void match_beat(logic [7:0] b, logic [1:0] user, logic last);
			frag_beat_t e;
			beats_out++;
			if (owed_bytes.size() == 0) begin
				$error("unexpected output beat: out_byte %0h", b);
				errors++;
				return;
			end
			e = owed_bytes.pop_front();
			if (b !== e.out_byte) begin
				$error("out_byte: expected %0h, got %0h", e.out_byte, b);
				errors++;
			end
			if (user[0] !== e.frag_end) begin
				$error("fragment_end: expected %0b, got %0b", e.frag_end, user[0]);
				errors++;
			end
			if (user[1] !== e.msg_end) begin
				$error("message_end: expected %0b, got %0b", e.msg_end, user[1]);
				errors++;
			end
			if (last !== e.run_last) begin
				$error("run_last: expected %0b, got %0b", e.run_last, last);
				errors++;
			end
		endfunction

		function void wrap_up();
			while (owed_bytes.size() != 0) begin
				frag_beat_t e;
				e = owed_bytes.pop_front();
				$error("missing output beat: out_byte %0h", e.out_byte);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	logic              s_tvalid;
	logic              s_tready;
	logic [23:0]       s_tdata;  // data_byte [7:0], msg_length [23:8]
	logic              m_tvalid;
	logic              m_tready;
	logic [7:0]        m_tdata;  // out_byte [7:0]
	logic [1:0]        m_tuser;  // fragment_end [0], message_end [1]
	logic              m_tlast;  // run_last

	fragment_tracker tracker = new();

	// idling controls for the sender and the receiver
	bit in_calm;
	bit out_calm;
	bit long_hold_req;
	int size_writes;

	message_fragmenter_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// overall time limit, far above the slowest legal run
	initial begin
		#2_000_000;
		$display("testbench: FAIL");
		$finish;
	end

	// both handshakes sampled at the rising edge; outputs checked before
	// inputs, an output beat can never come from the same edge's input
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) tracker.match_beat(m_tdata, m_tuser, m_tlast);
			if (s_tvalid && s_tready) tracker.take_byte(s_tdata[7:0], s_tdata[23:8]);
		end
	end

	// receiver: random hold before each beat, or one long hold on request
	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			hold = out_calm ? 0 : $urandom_range(0, 7);
			if (long_hold_req) begin
				hold = LONG_HOLD;
				long_hold_req = 1'b0;
			end
			if (hold > 0) begin
				m_tready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	// register write, setup then access; called at a falling edge
	task automatic size_write(input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_FRAGMENT_PAYLOAD;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		tracker.set_size(value[7:0]);
		size_writes++;
	endtask

	// one input beat; entered and left at a falling edge, tvalid left high
	// so a following beat can go out back to back
	task automatic send_byte(input logic [7:0] data, input logic [15:0] len);
		int gap;
		gap = in_calm ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  <= {len, data};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	// drop tvalid, wait for every owed byte, then let the pipeline go quiet
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0) @(negedge clk);
		repeat (IDLE_TAIL) @(negedge clk);
	endtask

	// one random beat: mostly well-formed messages, some zero-length starts
	// and some mid-message beats with a stray length
	task automatic random_item(output bit dropped);
		int          r;
		logic [15:0] len;
		dropped = 1'b0;
		if (!tracker.open()) begin
			r = $urandom_range(0, 99);
			if (r < 6) begin
				send_byte(8'($urandom_range(0, 255)), 16'd0);
				dropped = 1'b1;
			end else begin
				if (r < 75) len = 16'($urandom_range(1, 16));
				else if (r < 95) len = 16'($urandom_range(17, 60));
				else len = 16'($urandom_range(61, 120));
				send_byte(8'($urandom_range(0, 255)), len);
			end
		end else begin
			if ($urandom_range(0, 9) == 0) len = 16'($urandom_range(0, 65535));
			else len = tracker.cur_length();
			send_byte(8'($urandom_range(0, 255)), len);
		end
	endtask

	task automatic run_items(input int count);
		int  done;
		bit  dropped;
		done = 0;
		while (done < count) begin
			random_item(dropped);
			if (!dropped) done++;
		end
	endtask

	initial begin
		int          fsizes[9];
		logic [15:0] big_len;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		m_tready = 1'b0;
		in_calm  = 1'b0;
		out_calm = 1'b0;
		long_hold_req = 1'b0;
		size_writes = 0;
		arst_n   = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, reset fragment size: zero-length start is dropped,
		// one-byte messages with extreme data, stray length mid-message
		send_byte(8'hAA, 16'd0);
		send_byte(8'h00, 16'd1);
		send_byte(8'hFF, 16'd1);
		send_byte(8'h5A, 16'd2);
		send_byte(8'hA5, 16'hFFFF);
		wait_idle();

		// size below the minimum acts as the minimum: one data byte fits
		// the start fragment, later fragments carry four
		size_write(32'd0);
		send_byte(8'h11, 16'd1);
		send_byte(8'h22, 16'd2);
		send_byte(8'h33, 16'd0);
		repeat (5) send_byte(8'($urandom_range(0, 255)), 16'd5);
		wait_idle();

		// open a fragment of 14 bytes, then shrink the size below its fill
		// so the next data byte closes it
		size_write(32'd20);
		send_byte(8'($urandom_range(0, 255)), 16'd30);
		repeat (9) send_byte(8'($urandom_range(0, 255)), 16'd30);
		wait_idle();
		size_write(32'd6);
		repeat (3) send_byte(8'($urandom_range(0, 255)), 16'd30);
		wait_idle();

		// random phases over several sizes, the clamped extremes among them;
		// a message left open carries into the next size
		fsizes = '{5, 255, 6, 245, 4, 17, 0, 244, 0};
		fsizes[8] = $urandom_range(7, 60);
		foreach (fsizes[k]) begin
			size_write(32'(fsizes[k]));
			in_calm  = (k % 3 == 2);
			out_calm = (k % 3 == 2);
			if (k == 1 || k == 5) begin
				// sender runs flat out while the receiver holds off
				in_calm  = 1'b1;
				out_calm = 1'b0;
				long_hold_req = 1'b1;
			end
			run_items(32);
			wait_idle();
		end

		// largest size: close whatever is open, then start a message too long
		// for the start fragment, with the high length bits set
		in_calm  = 1'b0;
		out_calm = 1'b0;
		size_write(32'd244);
		while (tracker.open()) run_items(1);
		big_len = 16'($urandom_range(16'hF000, 16'hFFFF));
		send_byte(8'($urandom_range(0, 255)), big_len);
		repeat (15) send_byte(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
		wait_idle();
		repeat (20) @(negedge clk);

		tracker.wrap_up();
		$display("run covered %0d input beats (%0d dropped), %0d messages, %0d output beats",
			tracker.beats_in, tracker.dropped, tracker.messages, tracker.beats_out);
		$display("fragment size written %0d times, clamped extremes and mid-message changes",
			size_writes);
		if (tracker.errors == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule

/* message_fragmenter_core.f */
+incdir+rtl
rtl/mfrag_pkg.sv
rtl/message_fragmenter_core.sv
rtl/mfrag_checker.sv
tb/testbench.sv
